>>> rtl/core/obse_pkg.sv
// Shared types, codes and helpers for the order book side engine.
package obse_pkg;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_CANCEL = 3'd1,
      OP_PEEK   = 3'd2,
      OP_POP    = 3'd3,
      OP_FOK    = 3'd4,
      OP_SUMM   = 3'd5
   } op_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic [31:0] order_id;
      logic [23:0] price;
      logic [31:0] quantity;
      logic [15:0] owner;
   } entry_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic drop;
   } cell_ctrl_type;

   function automatic logic better(input logic bid, input logic [23:0] a,
                                   input logic [23:0] b);
      better = bid ? (a > b) : (a < b);
   endfunction

endpackage

>>> rtl/core/obse_cell.sv
// One book slot of the rotating cell chain.
module obse_cell #(
   parameter int BOOK_DEPTH = 256,
   parameter int IDX = 0
) (
   input  logic                               clock,
   input  obse_pkg::cell_ctrl_type            ctrl,
   input  logic [$clog2(BOOK_DEPTH+1)-1:0]    fill,
   input  obse_pkg::entry_type                load_data,
   input  obse_pkg::entry_type                head_data,
   input  obse_pkg::entry_type                next_data,
   output obse_pkg::entry_type                data
);

   localparam int FILL_W = $clog2(BOOK_DEPTH + 1);

   obse_pkg::entry_type data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.load && fill == FILL_W'(IDX)) begin
         data_in = load_data;
      end else if (ctrl.shift) begin
         if (fill > FILL_W'(IDX + 1)) begin
            data_in = next_data;
         end else if (fill == FILL_W'(IDX + 1) && !ctrl.drop) begin
            data_in = head_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> rtl/core/order_book_side_engine_top.sv
// Top level of the order book side engine: control sequencer and cell chain.
// Usage: items arrive on req_* (valid/stall) and each gives one or more results
// on rsp_* (valid/stall); rsp_last marks the final result of an item. Orders
// live in a chain of BOOK_DEPTH cells in arrival order; a scan rotates the
// occupied cells past cell 0, one order per cycle, and restores the order.
// Steps per item: add and an unused op go straight to the result. Cancel and
// peek make one scan; pop scans for the best price, then drops the first order
// at it in a second scan. Fill-or-kill scans for the next level and walks it,
// level after level, until the quantity is met, an own order with cancel_incoming
// ends it, the levels run out or the limit price stops it. Summarize walks each
// level, sends a record per level up to depth_limit, then the totals.
// One item is worked at a time; req_stall is high while an item is in work.
// Results sit in an output register; while rsp_stall is high it holds and
// a further result waits. Reset empties the book, sets ask ordering and a depth
// limit of 10. Registers (psel/penable APB write) are 0 side_is_bid at
// address 0 and 1 depth_limit at address 4.
module order_book_side_engine_top #(
   parameter int BOOK_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_order_id,
   input  logic [23:0] req_price_ticks,
   input  logic [31:0] req_quantity,
   input  logic [15:0] req_owner,
   input  logic        req_is_limit,
   input  logic        req_cancel_incoming,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_found,
   output logic [31:0] rsp_out_order_id,
   output logic [23:0] rsp_out_price,
   output logic [39:0] rsp_out_quantity,
   output logic [15:0] rsp_out_owner,
   output logic [8:0]  rsp_out_count,
   output logic [63:0] rsp_notional,
   output logic        rsp_is_totals,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int FILL_W = $clog2(BOOK_DEPTH + 1);
   localparam logic REG_SIDE  = 1'b0;
   localparam logic REG_DEPTH = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE, S_LEVEL, S_WALK, S_CANCEL, S_POP, S_EMIT, S_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in, cnt_ff, cnt_in;
   obse_pkg::op_type op_ff, op_in;
   logic [31:0] id_ff, id_in, need_ff, need_in;
   logic [23:0] price_ff, price_in, lvl_ff, lvl_in, best_ff, best_in;
   logic [15:0] own_ff, own_in;
   logic lim_ff, lim_in, cin_ff, cin_in;
   logic have_ff, have_in, got_ff, got_in, done_ff, done_in, pass_ff, pass_in;
   obse_pkg::entry_type fr_ff, fr_in;
   logic [32:0] avail_ff, avail_in, avail_sum;
   logic [39:0] lq_ff, lq_in, tq_ff, tq_in;
   logic [8:0]  lc_ff, lc_in, tc_ff, tc_in;
   logic [63:0] tn_ff, tn_in;
   logic [55:0] prod_ff, prod_in;
   logic pv_ff, pv_in;
   logic [5:0] n_ff, n_in;
   logic side_ff, side_in;
   logic [5:0] depth_ff, depth_in;
   // pending result
   logic [1:0]  r_status_ff, r_status_in;
   logic        r_found_ff, r_found_in, r_totals_ff, r_totals_in;
   logic [31:0] r_id_ff, r_id_in;
   logic [23:0] r_price_ff, r_price_in;
   logic [39:0] r_qty_ff, r_qty_in;
   logic [15:0] r_owner_ff, r_owner_in;
   logic [8:0]  r_count_ff, r_count_in;
   logic [63:0] r_notional_ff, r_notional_in;
   // output register
   logic        o_valid_ff, o_valid_in, o_last_ff, o_last_in;
   logic [1:0]  o_status_ff, o_status_in;
   logic        o_found_ff, o_found_in, o_totals_ff, o_totals_in;
   logic [31:0] o_id_ff, o_id_in;
   logic [23:0] o_price_ff, o_price_in;
   logic [39:0] o_qty_ff, o_qty_in;
   logic [15:0] o_owner_ff, o_owner_in;
   logic [8:0]  o_count_ff, o_count_in;
   logic [63:0] o_notional_ff, o_notional_in;

   obse_pkg::cell_ctrl_type ctrl;
   obse_pkg::entry_type     load_data, head;
   obse_pkg::entry_type     cells [BOOK_DEPTH];
   logic out_free, cfg_wr;

   assign load_data = '{order_id: req_order_id, price: req_price_ticks,
                        quantity: req_quantity, owner: req_owner};
   assign head = cells[0];

   for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
      obse_cell #(.BOOK_DEPTH(BOOK_DEPTH), .IDX(i)) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .fill      (fill_ff),
         .load_data (load_data),
         .head_data (cells[0]),
         .next_data (cells[(i + 1) % BOOK_DEPTH]),
         .data      (cells[i])
      );
   end

   assign out_free = !o_valid_ff || !rsp_stall;
   assign cfg_wr   = psel && penable && pwrite && pready;
   assign pready   = 1'b1;
   assign prdata   = (paddr[2] == REG_DEPTH) ? {26'd0, depth_ff} : {31'd0, side_ff};
   assign avail_sum = avail_ff + {1'b0, head.quantity};

   always_comb begin
      state_in = state_ff;  fill_in = fill_ff;  cnt_in = cnt_ff;
      op_in = op_ff;  id_in = id_ff;  need_in = need_ff;  price_in = price_ff;
      own_in = own_ff;  lim_in = lim_ff;  cin_in = cin_ff;
      lvl_in = lvl_ff;  best_in = best_ff;  have_in = have_ff;  got_in = got_ff;
      done_in = done_ff;  pass_in = pass_ff;  fr_in = fr_ff;  avail_in = avail_ff;
      lq_in = lq_ff;  lc_in = lc_ff;  tq_in = tq_ff;  tc_in = tc_ff;  tn_in = tn_ff;
      prod_in = prod_ff;  pv_in = 1'b0;  n_in = n_ff;
      side_in = side_ff;  depth_in = depth_ff;
      r_status_in = r_status_ff;  r_found_in = r_found_ff;  r_totals_in = r_totals_ff;
      r_id_in = r_id_ff;  r_price_in = r_price_ff;  r_qty_in = r_qty_ff;
      r_owner_in = r_owner_ff;  r_count_in = r_count_ff;  r_notional_in = r_notional_ff;
      o_valid_in = o_valid_ff;  o_last_in = o_last_ff;  o_status_in = o_status_ff;
      o_found_in = o_found_ff;  o_totals_in = o_totals_ff;  o_id_in = o_id_ff;
      o_price_in = o_price_ff;  o_qty_in = o_qty_ff;  o_owner_in = o_owner_ff;
      o_count_in = o_count_ff;  o_notional_in = o_notional_ff;
      ctrl = '0;

      if (cfg_wr) begin
         if (paddr[2] == REG_SIDE) begin
            side_in = pwdata[0];
         end else begin
            depth_in = pwdata[5:0];
         end
      end
      if (o_valid_ff && !rsp_stall) begin
         o_valid_in = 1'b0;
      end
      if (pv_ff) begin
         tn_in = tn_ff + 64'(prod_ff);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = obse_pkg::op_type'(req_op);
               id_in = req_order_id;  price_in = req_price_ticks;
               need_in = req_quantity;  own_in = req_owner;
               lim_in = req_is_limit;  cin_in = req_cancel_incoming;
               r_status_in = obse_pkg::ST_OK;  r_found_in = 1'b0;  r_totals_in = 1'b0;
               r_id_in = '0;  r_price_in = '0;  r_qty_in = '0;  r_owner_in = '0;
               r_count_in = '0;  r_notional_in = '0;
               cnt_in = fill_ff;  got_in = 1'b0;  have_in = 1'b0;  done_in = 1'b0;
               pass_in = 1'b0;  avail_in = '0;  tq_in = '0;  tc_in = '0;  tn_in = '0;
               n_in = '0;
               unique case (req_op)
                  obse_pkg::OP_ADD: begin
                     if (fill_ff == FILL_W'(BOOK_DEPTH)) begin
                        r_status_in = obse_pkg::ST_FULL;
                     end else begin
                        ctrl.load = 1'b1;
                        fill_in = fill_ff + 1'b1;
                     end
                     state_in = S_RESULT;
                  end
                  obse_pkg::OP_CANCEL: state_in = S_CANCEL;
                  obse_pkg::OP_PEEK, obse_pkg::OP_POP,
                  obse_pkg::OP_FOK, obse_pkg::OP_SUMM: state_in = S_LEVEL;
                  default: state_in = S_RESULT;
               endcase
            end
         end
         S_LEVEL: begin
            if (cnt_ff != '0) begin
               ctrl.shift = 1'b1;
               cnt_in = cnt_ff - 1'b1;
               if ((!have_ff || obse_pkg::better(side_ff, lvl_ff, head.price)) &&
                   (!got_ff || obse_pkg::better(side_ff, head.price, best_ff))) begin
                  best_in = head.price;  got_in = 1'b1;  fr_in = head;
               end
            end else begin
               unique case (op_ff)
                  obse_pkg::OP_PEEK, obse_pkg::OP_POP: begin
                     state_in = S_RESULT;
                     if (got_ff) begin
                        r_found_in = 1'b1;  r_id_in = fr_ff.order_id;
                        r_price_in = fr_ff.price;  r_qty_in = 40'(fr_ff.quantity);
                        r_owner_in = fr_ff.owner;
                        if (op_ff == obse_pkg::OP_POP) begin
                           cnt_in = fill_ff;  done_in = 1'b0;  state_in = S_POP;
                        end
                     end
                  end
                  obse_pkg::OP_FOK: begin
                     if (!got_ff || (lim_ff && obse_pkg::better(side_ff, price_ff, best_ff)))
                     begin
                        state_in = S_RESULT;
                     end else begin
                        lvl_in = best_ff;  have_in = 1'b1;  cnt_in = fill_ff;
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     if (!got_ff) begin
                        r_price_in = '0;  r_qty_in = tq_ff;  r_count_in = tc_ff;
                        r_notional_in = tn_ff;  r_totals_in = 1'b1;
                        state_in = S_RESULT;
                     end else begin
                        lvl_in = best_ff;  have_in = 1'b1;  cnt_in = fill_ff;
                        lq_in = '0;  lc_in = '0;
                        state_in = S_WALK;
                     end
                  end
               endcase
            end
         end
         S_WALK: begin
            if (cnt_ff != '0) begin
               ctrl.shift = 1'b1;
               cnt_in = cnt_ff - 1'b1;
               if (head.price == lvl_ff) begin
                  if (op_ff == obse_pkg::OP_FOK) begin
                     if (!done_ff) begin
                        if (head.owner == own_ff) begin
                           if (cin_ff) begin
                              done_in = 1'b1;  pass_in = 1'b0;
                           end
                        end else begin
                           avail_in = avail_sum;
                           if (avail_sum >= {1'b0, need_ff}) begin
                              done_in = 1'b1;  pass_in = 1'b1;
                           end
                        end
                     end
                  end else begin
                     lq_in = lq_ff + 40'(head.quantity);
                     lc_in = lc_ff + 1'b1;
                     tq_in = tq_ff + 40'(head.quantity);
                     tc_in = tc_ff + 1'b1;
                     prod_in = head.price * head.quantity;
                     pv_in = 1'b1;
                  end
               end
            end else if (op_ff == obse_pkg::OP_FOK) begin
               if (done_ff) begin
                  r_found_in = pass_ff;  state_in = S_RESULT;
               end else begin
                  cnt_in = fill_ff;  got_in = 1'b0;  state_in = S_LEVEL;
               end
            end else if (n_ff < depth_ff) begin
               r_price_in = lvl_ff;  r_qty_in = lq_ff;  r_count_in = lc_ff;
               n_in = n_ff + 1'b1;
               state_in = S_EMIT;
            end else begin
               cnt_in = fill_ff;  got_in = 1'b0;  state_in = S_LEVEL;
            end
         end
         S_CANCEL, S_POP: begin
            if (cnt_ff != '0) begin
               ctrl.shift = 1'b1;
               cnt_in = cnt_ff - 1'b1;
               if (!done_ff && ((state_ff == S_CANCEL) ? (head.order_id == id_ff)
                                                       : (head.price == best_ff))) begin
                  ctrl.drop = 1'b1;  done_in = 1'b1;  fill_in = fill_ff - 1'b1;
               end
            end else begin
               if (state_ff == S_CANCEL && !done_ff) begin
                  r_status_in = obse_pkg::ST_NOT_FOUND;
               end
               state_in = S_RESULT;
            end
         end
         S_EMIT, S_RESULT: begin
            if (out_free) begin
               o_valid_in = 1'b1;  o_last_in = (state_ff == S_RESULT);
               o_status_in = r_status_ff;  o_found_in = r_found_ff;
               o_totals_in = r_totals_ff;  o_id_in = r_id_ff;  o_price_in = r_price_ff;
               o_qty_in = r_qty_ff;  o_owner_in = r_owner_ff;  o_count_in = r_count_ff;
               o_notional_in = r_notional_ff;
               if (state_ff == S_RESULT) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in = fill_ff;  got_in = 1'b0;  state_in = S_LEVEL;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;  fill_ff <= '0;  o_valid_ff <= 1'b0;  pv_ff <= 1'b0;
         side_ff <= 1'b0;  depth_ff <= 6'd10;
      end else begin
         state_ff <= state_in;  fill_ff <= fill_in;  o_valid_ff <= o_valid_in;
         pv_ff <= pv_in;  side_ff <= side_in;  depth_ff <= depth_in;
      end
      cnt_ff <= cnt_in;  op_ff <= op_in;  id_ff <= id_in;  need_ff <= need_in;
      price_ff <= price_in;  own_ff <= own_in;  lim_ff <= lim_in;  cin_ff <= cin_in;
      lvl_ff <= lvl_in;  best_ff <= best_in;  have_ff <= have_in;  got_ff <= got_in;
      done_ff <= done_in;  pass_ff <= pass_in;  fr_ff <= fr_in;  avail_ff <= avail_in;
      lq_ff <= lq_in;  lc_ff <= lc_in;  tq_ff <= tq_in;  tc_ff <= tc_in;  tn_ff <= tn_in;
      prod_ff <= prod_in;  n_ff <= n_in;
      r_status_ff <= r_status_in;  r_found_ff <= r_found_in;  r_totals_ff <= r_totals_in;
      r_id_ff <= r_id_in;  r_price_ff <= r_price_in;  r_qty_ff <= r_qty_in;
      r_owner_ff <= r_owner_in;  r_count_ff <= r_count_in;
      r_notional_ff <= r_notional_in;
      o_last_ff <= o_last_in;  o_status_ff <= o_status_in;  o_found_ff <= o_found_in;
      o_totals_ff <= o_totals_in;  o_id_ff <= o_id_in;  o_price_ff <= o_price_in;
      o_qty_ff <= o_qty_in;  o_owner_ff <= o_owner_in;  o_count_ff <= o_count_in;
      o_notional_ff <= o_notional_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = o_valid_ff;
   assign rsp_last         = o_last_ff;
   assign rsp_status       = o_status_ff;
   assign rsp_found        = o_found_ff;
   assign rsp_out_order_id = o_id_ff;
   assign rsp_out_price    = o_price_ff;
   assign rsp_out_quantity = o_qty_ff;
   assign rsp_out_owner    = o_owner_ff;
   assign rsp_out_count    = o_count_ff;
   assign rsp_notional     = o_notional_ff;
   assign rsp_is_totals    = o_totals_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(BOOK_DEPTH))
      else $error("book fill beyond depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LEVEL || state_ff == S_WALK || state_ff == S_CANCEL ||
       state_ff == S_POP) |-> cnt_ff <= fill_ff)
      else $error("scan count beyond fill");

   a_drop_src: assert property (@(posedge clock) disable iff (reset)
      (fill_ff < $past(fill_ff)) |->
         ($past(state_ff) == S_CANCEL || $past(state_ff) == S_POP))
      else $error("order removed outside cancel or pop");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last && !rsp_stall && state_ff == S_IDLE) |=> !rsp_valid
         || $past(state_ff) == S_IDLE)
      else $error("final result followed by stray result");

endmodule
